FILE: design/vic_pkg.sv
package vic_pkg;

    // Number of interrupt lines wired to the controller (2 to 64).
    localparam int unsigned IRQ_LINES = 64;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned LINE_W = 6;
    localparam int unsigned VEC_SHIFT = 3;

    // Lines at or above IRQ_LINES never take part in selection.
    localparam logic [DATA_W-1:0] LINE_MASK =
        (IRQ_LINES >= DATA_W) ? {DATA_W{1'b1}}
                              : ((64'd1 << IRQ_LINES) - 64'd1);

    typedef enum logic [2:0] {
        KIND_RAISE = 3'd0,
        KIND_CLEAR = 3'd1,
        KIND_READ  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_SERVE = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_PENDING = 3'd0,
        REG_ENABLE  = 3'd1,
        REG_CONTROL = 3'd2,
        REG_VBASE   = 3'd3,
        REG_CURRENT = 3'd4,
        REG_ACK     = 3'd5
    } reg_index_t;

endpackage

FILE: design/vectored_interrupt_controller.sv
// Vectored interrupt controller, fixed priority (lowest line wins).
// Input channel (in_valid/in_ready) carries one command per beat: raise or
// clear a line, a bus read or write of a register, or a serve request.
// Output channel (out_valid/out_ready) returns exactly one result beat per
// command: read data, and for a taken serve the line and its vector address.
// A command lands in an input register; the mask update, priority encode
// and vector add run combinationally on it, and the result lands in the
// output register.
// Throughput is one command per cycle while the receiver does not stall; the
// single 64-bit vector add and the 64-line priority encoder set the cycle path.
// While the receiver stalls, the held result stays put and one more command
// may wait in the input register; in_ready drops only when both are full.
// Commands take effect on the masks in order, one per cycle of progress.
// Reset clears all masks, the control word, the vector base and the current
// interrupt, and empties both registers.
module vectored_interrupt_controller
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [6:0]  line_num,
    input  logic [2:0]  reg_index,
    input  logic [63:0] write_data,
    input  logic        core_busy,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] read_data,
    output logic        serve_taken,
    output logic [5:0]  serve_line,
    output logic [63:0] vec_address
);

    localparam int unsigned DW = vic_pkg::DATA_W;
    localparam int unsigned LW = vic_pkg::LINE_W;

    // input register
    logic          in_valid_reg;
    logic [2:0]    kind_reg;
    logic [6:0]    line_reg;
    logic [2:0]    idx_reg;
    logic [DW-1:0] data_reg;
    logic          busy_reg;

    // controller state
    logic [DW-1:0] pending_reg, pending_next;
    logic [DW-1:0] enable_reg, enable_next;
    logic [DW-1:0] control_reg, control_next;
    logic [DW-1:0] vbase_reg, vbase_next;
    logic          cur_valid_reg, cur_valid_next;
    logic [LW-1:0] cur_line_reg, cur_line_next;

    // output register
    logic          out_valid_reg;
    logic [DW-1:0] rdata_reg, rdata_next;
    logic          taken_reg, taken_next;
    logic [LW-1:0] sline_reg, sline_next;
    logic [DW-1:0] vaddr_reg, vaddr_next;

    logic          advance;
    logic          fire;
    logic [DW-1:0] active;
    logic          any_active;
    logic [LW-1:0] sel_line;
    logic [DW-1:0] line_onehot;
    logic          line_ok;
    logic [DW-1:0] sel_onehot;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    assign active     = pending_reg & enable_reg & vic_pkg::LINE_MASK;
    assign any_active = |active;

    always_comb
    begin
        sel_line = '0;
        for (int i = DW - 1; i >= 0; i--)
        begin
            if (active[i])
            begin
                sel_line = LW'(i);
            end
        end
    end

    assign line_ok     = (line_reg < 7'(vic_pkg::IRQ_LINES));
    assign line_onehot = line_ok ? (64'd1 << line_reg[LW-1:0]) : '0;
    assign sel_onehot  = 64'd1 << sel_line;

    always_comb
    begin
        pending_next   = pending_reg;
        enable_next    = enable_reg;
        control_next   = control_reg;
        vbase_next     = vbase_reg;
        cur_valid_next = cur_valid_reg;
        cur_line_next  = cur_line_reg;
        rdata_next     = '0;
        taken_next     = 1'b0;
        sline_next     = '0;
        vaddr_next     = '0;
        unique case (vic_pkg::kind_t'(kind_reg))
            vic_pkg::KIND_RAISE:
            begin
                pending_next = pending_reg | line_onehot;
            end
            vic_pkg::KIND_CLEAR:
            begin
                pending_next = pending_reg & ~line_onehot;
            end
            vic_pkg::KIND_READ:
            begin
                unique case (vic_pkg::reg_index_t'(idx_reg))
                    vic_pkg::REG_PENDING: rdata_next = pending_reg;
                    vic_pkg::REG_ENABLE:  rdata_next = enable_reg;
                    vic_pkg::REG_CONTROL: rdata_next = control_reg;
                    vic_pkg::REG_VBASE:   rdata_next = vbase_reg;
                    vic_pkg::REG_CURRENT:
                        rdata_next = cur_valid_reg ? DW'(cur_line_reg) : {DW{1'b1}};
                    default:              rdata_next = '0;
                endcase
            end
            vic_pkg::KIND_WRITE:
            begin
                unique case (vic_pkg::reg_index_t'(idx_reg))
                    vic_pkg::REG_PENDING: pending_next = pending_reg & ~data_reg;
                    vic_pkg::REG_ENABLE:  enable_next  = data_reg;
                    vic_pkg::REG_CONTROL: control_next = data_reg;
                    vic_pkg::REG_VBASE:   vbase_next   = data_reg;
                    vic_pkg::REG_ACK:
                    begin
                        if (cur_valid_reg && (data_reg == DW'(cur_line_reg)))
                        begin
                            cur_valid_next = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            vic_pkg::KIND_SERVE:
            begin
                if (control_reg[0] && !busy_reg && any_active)
                begin
                    cur_valid_next = 1'b1;
                    cur_line_next  = sel_line;
                    pending_next   = pending_reg & ~sel_onehot;
                    taken_next     = 1'b1;
                    sline_next     = sel_line;
                    vaddr_next     = vbase_reg + (DW'(sel_line) << vic_pkg::VEC_SHIFT);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
            enable_reg    <= '0;
            control_reg   <= '0;
            vbase_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_line_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                pending_reg   <= pending_next;
                enable_reg    <= enable_next;
                control_reg   <= control_next;
                vbase_reg     <= vbase_next;
                cur_valid_reg <= cur_valid_next;
                cur_line_reg  <= cur_line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg <= kind;
            line_reg <= line_num;
            idx_reg  <= reg_index;
            data_reg <= write_data;
            busy_reg <= core_busy;
        end
        if (fire)
        begin
            rdata_reg <= rdata_next;
            taken_reg <= taken_next;
            sline_reg <= sline_next;
            vaddr_reg <= vaddr_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = rdata_reg;
    assign serve_taken = taken_reg;
    assign serve_line  = sline_reg;
    assign vec_address = vaddr_reg;

endmodule
